// File: hw/rtl/wbss_pkg.sv
// shared types, constants and helper functions of the wildcard byte signature scanner
`timescale 1ns / 1ps

package wbss_pkg;

  // default window depth, and the number of signature bytes held in the registers
  localparam int MAX_PATTERN = 16;
  localparam int SIG_BYTES   = 16;

  // width of signature position indexes, enough for a window of up to 127 bytes
  localparam int SIG_IDX_W = 7;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WILD_MASK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDR = 3'd4;

  // what one window cell compares against
  typedef struct packed {
    logic [7:0] exp_byte;
    logic       wild;
    logic       in_use;
  } cell_cmp_t;

  // one result request
  typedef struct packed {
    logic        found;
    logic [31:0] match_address;
  } result_t;

  // signature byte at a position, zero beyond the sixteen held bytes
  function automatic logic [7:0] sig_byte(input logic [8*SIG_BYTES-1:0] pat,
                                          input logic [SIG_IDX_W-1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    if (idx < SIG_IDX_W'(SIG_BYTES)) begin
      b = pat[{idx[3:0], 3'b000} +: 8];
    end
    return b;
  endfunction

  // wildcard flag at a position, never set beyond the sixteen held bytes
  function automatic logic sig_wild(input logic [SIG_BYTES-1:0] mask,
                                    input logic [SIG_IDX_W-1:0] idx);
    logic w;
    w = 1'b0;
    if (idx < SIG_IDX_W'(SIG_BYTES)) begin
      w = mask[idx[3:0]];
    end
    return w;
  endfunction

endpackage

// File: hw/rtl/wildcard_byte_signature_scan.sv
// top level of the wildcard byte signature scanner: config, window cells and result control
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  in_data_byte, in_last_byte
//   out_     output     out_valid/out_stall out_found, out_match_address
//   cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// one byte request is taken every cycle while in_stall is low; the row of window
// cells compares all positions at once, so the cell row and the address adder set the cycle
// a result is in the output buffer in the cycle after the byte that causes it
// the two-entry result buffer stalls input only when two results wait
// synchronous active-low reset; nothing needs a clearing pass
`timescale 1ns / 1ps

module wildcard_byte_signature_scan #(
  parameter int MAX_PATTERN = wbss_pkg::MAX_PATTERN
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_last_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_found,
  output logic [31:0]                    out_match_address,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wbss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data
);

  localparam int IW = wbss_pkg::SIG_IDX_W;

  // configuration registers
  logic [63:0] pat_low_r;
  logic [63:0] pat_high_r;
  logic [15:0] wild_mask_r;
  logic [4:0]  pat_len_r;
  logic [31:0] base_addr_r;

  // search state
  logic [31:0] offset_r, offset_nxt;
  logic        already_found_r, already_found_nxt;

  logic              acc;
  logic              buf_full;
  logic [IW-1:0]     len_x;
  logic [31:0]       len_m1;
  logic [MAX_PATTERN-1:0] hit;
  logic [7:0]        win_byte [MAX_PATTERN];
  logic              match;
  logic              res_push;
  logic [31:0]       start_sum;
  wbss_pkg::result_t res_data;
  wbss_pkg::result_t head;

  assign cfg_ready = 1'b1;
  assign in_stall  = buf_full;
  assign acc       = in_valid && !in_stall;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r   <= 64'd0;
      pat_high_r  <= 64'd0;
      wild_mask_r <= 16'd0;
      pat_len_r   <= 5'd1;
      base_addr_r <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wbss_pkg::CFG_PAT_LOW:   pat_low_r   <= cfg_data;
        wbss_pkg::CFG_PAT_HIGH:  pat_high_r  <= cfg_data;
        wbss_pkg::CFG_WILD_MASK: wild_mask_r <= cfg_data[15:0];
        wbss_pkg::CFG_PAT_LEN:   pat_len_r   <= cfg_data[4:0];
        wbss_pkg::CFG_BASE_ADDR: base_addr_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // effective signature length, zero taken as one and clipped to the window
  always_comb begin
    len_x = IW'(pat_len_r);
    if (pat_len_r == 5'd0) begin
      len_x = IW'(1);
    end else if (IW'(pat_len_r) > IW'(MAX_PATTERN)) begin
      len_x = IW'(MAX_PATTERN);
    end
  end

  assign len_m1 = 32'(len_x) - 32'd1;

  // row of window cells, cell k holds the k-th newest byte
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [IW-1:0]       sig_idx;
    logic [7:0]          byte_in;
    wbss_pkg::cell_cmp_t cmp;

    assign sig_idx      = len_x - IW'(k) - IW'(1);
    assign cmp.in_use   = IW'(k) < len_x;
    assign cmp.exp_byte = wbss_pkg::sig_byte({pat_high_r, pat_low_r}, sig_idx);
    assign cmp.wild     = wbss_pkg::sig_wild(wild_mask_r, sig_idx);

    if (k == 0) begin : g_head
      assign byte_in = in_data_byte;
    end else begin : g_tail
      assign byte_in = win_byte[k-1];
    end

    wbss_cell u_cell (
      .clk      (clk),
      .shift_en (acc),
      .byte_in  (byte_in),
      .cmp      (cmp),
      .byte_out (win_byte[k]),
      .hit      (hit[k])
    );
  end

  // match decision and start address
  assign match = !already_found_r && (offset_r >= len_m1) &&
                 !(in_last_byte && (len_x == IW'(1))) && (&hit);
  assign start_sum = base_addr_r + offset_r - len_m1;

  assign res_push               = acc && (match || (in_last_byte && !already_found_r));
  assign res_data.found         = match;
  assign res_data.match_address = match ? start_sum : 32'd0;

  // offset and found flag, cleared by the final byte
  always_comb begin
    offset_nxt        = offset_r;
    already_found_nxt = already_found_r;
    if (acc) begin
      if (in_last_byte) begin
        offset_nxt        = 32'd0;
        already_found_nxt = 1'b0;
      end else begin
        if (offset_r != 32'hFFFF_FFFF) begin
          offset_nxt = offset_r + 32'd1;
        end
        already_found_nxt = already_found_r || match;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r        <= 32'd0;
      already_found_r <= 1'b0;
    end else begin
      offset_r        <= offset_nxt;
      already_found_r <= already_found_nxt;
    end
  end

  // result buffer
  wbss_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (head)
  );

  assign out_found         = head.found;
  assign out_match_address = head.match_address;

  // final byte clears the search state
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_last_byte |=> (offset_r == 32'd0) && !already_found_r)
    else $error("search state not cleared after final byte");

  // a found result marks the region as done
  a_found_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && res_data.found && !in_last_byte |=> already_found_r)
    else $error("found flag not set after match");

  // the result buffer never takes a request while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_push && buf_full))
    else $error("result buffer overflow");

  // offset never moves back inside a region
  a_offset_mono: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !in_last_byte |=> offset_r >= $past(offset_r))
    else $error("offset moved back");

endmodule

// File: hw/rtl/wbss_cell.sv
// one window cell: holds a recent byte, passes it on and compares its incoming byte
`timescale 1ns / 1ps

module wbss_cell (
  input  logic                 clk,
  input  logic                 shift_en,
  input  logic [7:0]           byte_in,
  input  wbss_pkg::cell_cmp_t  cmp,
  output logic [7:0]           byte_out,
  output logic                 hit
);

  logic [7:0] byte_r;

  // window byte, shifted on each accepted request
  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;

  // compare the byte this cell takes in this cycle
  assign hit = !cmp.in_use || cmp.wild || (byte_in == cmp.exp_byte);

endmodule

// File: hw/rtl/wbss_out_buf.sv
// two-entry result buffer between the scan logic and the result channel
`timescale 1ns / 1ps

module wbss_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  wbss_pkg::result_t  push_data,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output wbss_pkg::result_t  out_data
);

  logic [1:0]        cnt_r, cnt_nxt;
  wbss_pkg::result_t e0_r, e0_nxt;
  wbss_pkg::result_t e1_r, e1_nxt;
  logic              pop;

  assign pop       = (cnt_r != 2'd0) && !out_stall;
  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = e0_r;

  // next entries and fill count
  always_comb begin
    cnt_nxt = cnt_r;
    e0_nxt  = e0_r;
    e1_nxt  = e1_r;
    if (pop && push) begin
      if (cnt_r == 2'd2) begin
        e0_nxt = e1_r;
        e1_nxt = push_data;
      end else begin
        e0_nxt = push_data;
      end
    end else if (pop) begin
      e0_nxt  = e1_r;
      cnt_nxt = cnt_r - 2'd1;
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        e0_nxt = push_data;
      end else begin
        e1_nxt = push_data;
      end
      cnt_nxt = cnt_r + 2'd1;
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // entries
  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

endmodule

// File: tb/sv/tb_wildcard_byte_signature_scan.sv
// self-checking testbench of the wildcard byte signature scanner with its own search predictor
`timescale 1ns / 1ps

module tb_wildcard_byte_signature_scan;
  import wbss_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 4;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [7:0]           in_data_byte;
  logic                 in_last_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_found;
  logic [31:0]          out_match_address;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0]          cfg_data;

  // predictor copy of the registers
  logic [63:0] sig_lo;
  logic [63:0] sig_hi;
  logic [15:0] wild_mask;
  logic [4:0]  sig_len;
  logic [31:0] base_addr;

  // predictor copy of the search state
  logic [7:0]  window_bytes [MAX_PATTERN];
  logic [31:0] scan_offset;
  logic        scan_hit;

  result_t pending_outcomes[$];
  int      failures;
  int      cycle_count;
  bit      sender_gaps;
  bit      receiver_stalls;
  int      long_hold_cycles;

  wildcard_byte_signature_scan i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found         (out_found),
    .out_match_address (out_match_address),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // clock
  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // signature byte at a position of the programmed signature
  function automatic logic [7:0] sig_at(input int k);
    logic [127:0] s;
    s = {sig_hi, sig_lo};
    return s[8*k +: 8];
  endfunction

  // signature length actually compared
  function automatic int eff_len();
    int n;
    n = int'(sig_len);
    if (n == 0) n = 1;
    if (n > MAX_PATTERN) n = MAX_PATTERN;
    return n;
  endfunction

  // search state back to the start of a region
  task automatic clear_scan();
    foreach (window_bytes[i]) window_bytes[i] = 8'h00;
    scan_offset = '0;
    scan_hit    = 1'b0;
  endtask

  // predicts the outcome of one byte request
  task automatic scan_byte(input logic [7:0] d, input logic last);
    logic [31:0] cur;
    int          len;
    bit          ok;
    result_t     r;
    cur = scan_offset;
    len = eff_len();
    for (int i = MAX_PATTERN - 1; i > 0; i--) window_bytes[i] = window_bytes[i-1];
    window_bytes[0] = d;
    if (scan_offset != '1) scan_offset++;
    // masked compare once enough bytes are in, never starting on the final byte
    if (!scan_hit && cur >= 32'(len - 1) && !(last && len == 1)) begin
      ok = 1'b1;
      for (int i = 0; i < len; i++) begin
        if (!wild_mask[i] && window_bytes[len-1-i] != sig_at(i)) ok = 1'b0;
      end
      if (ok) begin
        scan_hit        = 1'b1;
        r.found         = 1'b1;
        r.match_address = base_addr + cur - 32'(len - 1);
        pending_outcomes.push_back(r);
      end
    end
    // end of region: not found unless already reported
    if (last) begin
      if (!scan_hit) begin
        r.found         = 1'b0;
        r.match_address = '0;
        pending_outcomes.push_back(r);
      end
      clear_scan();
    end
  endtask

  // byte requests into the predictor
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) scan_byte(in_data_byte, in_last_byte);
  end

  // register writes into the predictor
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PAT_LOW:   sig_lo = cfg_data;
        CFG_PAT_HIGH:  sig_hi = cfg_data;
        CFG_WILD_MASK: wild_mask = cfg_data[15:0];
        CFG_PAT_LEN:   sig_len = cfg_data[4:0];
        CFG_BASE_ADDR: base_addr = cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_outcomes.size() == 0) begin
        $error("unexpected result: found=%0d match_address=%h", out_found, out_match_address);
        failures++;
      end else begin
        want = pending_outcomes.pop_front();
        if (out_found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_found);
          failures++;
        end
        if (out_match_address !== want.match_address) begin
          $error("match_address: expected %h, got %h", want.match_address, out_match_address);
          failures++;
        end
      end
    end
  end

  // receiver: random stall bursts, or one long hold when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_cycles != 0) begin
        out_stall = 1'b1;
        repeat (long_hold_cycles) @(negedge clk);
        long_hold_cycles = 0;
        out_stall = 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 7) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        out_stall = 1'b0;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // one byte request, held until taken
  task automatic offer_byte(input logic [7:0] d, input logic last);
    @(negedge clk);
    if (sender_gaps && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_data_byte = d;
    in_last_byte = last;
    do @(posedge clk); while (in_stall);
  endtask

  // sender stops and waits for every expected result
  task automatic settle_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register write request
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // programs every register of the search
  task automatic program_search(input logic [63:0] lo, input logic [63:0] hi,
                                input logic [15:0] mask, input logic [4:0] len,
                                input logic [31:0] base);
    write_reg(CFG_PAT_LOW, lo);
    write_reg(CFG_PAT_HIGH, hi);
    write_reg(CFG_WILD_MASK, {48'($urandom), mask});
    write_reg(CFG_PAT_LEN, {59'({$urandom, $urandom}), len});
    write_reg(CFG_BASE_ADDR, {32'($urandom), base});
  endtask

  // one region, optionally with the signature planted or planted with one byte spoilt
  task automatic send_region(input int n, input bit plant, input bit spoil);
    logic [7:0] region_data[$];
    int         open_pos[$];
    int         len;
    int         start;
    int         pick;
    len = eff_len();
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 1) != 0) region_data.push_back(8'($urandom));
      else region_data.push_back(sig_at($urandom_range(0, MAX_PATTERN - 1)));
    end
    if ((plant || spoil) && n >= len) begin
      start = $urandom_range(0, n - len);
      for (int k = 0; k < len; k++) begin
        if (!wild_mask[k]) begin
          region_data[start+k] = sig_at(k);
          open_pos.push_back(k);
        end
      end
      if (spoil && open_pos.size() > 0) begin
        pick = open_pos[$urandom_range(0, open_pos.size() - 1)];
        region_data[start+pick] ^= 8'(1 << $urandom_range(0, 7));
      end
    end
    for (int k = 0; k < n; k++) offer_byte(region_data[k], k == n - 1);
  endtask

  // reset values, extremes, wrap, length clamping and the final-byte rules
  task automatic test_directed();
    logic [63:0] lo;
    logic [63:0] hi;
    // reset registers: one-byte signature 0x00, not tested on the final byte
    offer_byte(8'h00, 1'b1);
    offer_byte(8'hff, 1'b0);
    offer_byte(8'h00, 1'b0);
    offer_byte(8'h01, 1'b1);
    settle_idle();
    // writes to unused indexes must change nothing
    for (int idx = int'(CFG_BASE_ADDR) + 1; idx < (1 << CFG_IDX_W); idx++) begin
      write_reg(CFG_IDX_W'(idx), {$urandom, $urandom});
    end
    // length zero taken as one, address wraps past the top
    program_search(64'h0000_0000_0000_00ff, 64'hffff_ffff_ffff_ffff, 16'h0000, 5'd0,
                   32'hffff_ffff);
    offer_byte(8'h12, 1'b0);
    offer_byte(8'hff, 1'b0);
    offer_byte(8'h00, 1'b1);
    settle_idle();
    // too few bytes yet, then a match completing on the final byte
    program_search(64'h0, 64'h0, 16'hffff, 5'd2, $urandom);
    send_region(1, 1'b0, 1'b0);
    send_region(2, 1'b0, 1'b0);
    settle_idle();
    // oversize length clamped to sixteen, wildcards at both ends, match on final byte
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    program_search(lo, hi, 16'h8001, 5'd31, $urandom);
    send_region(MAX_PATTERN, 1'b1, 1'b0);
    settle_idle();
  endtask

  // receiver holds off long while bytes keep coming, so the input stalls
  task automatic test_result_backlog();
    sender_gaps = 1'b0;
    program_search({$urandom, $urandom}, {$urandom, $urandom}, 16'hffff, 5'd1, $urandom);
    long_hold_cycles = 300;
    for (int r = 0; r < 40; r++) send_region(2, 1'b0, 1'b0);
    settle_idle();
    sender_gaps = 1'b1;
  endtask

  // random signatures and regions, mostly with the signature planted
  task automatic test_random_regions();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [15:0] mask;
    logic [4:0]  plen;
    logic [31:0] base;
    int          sent;
    int          n;
    int          pick;
    for (int phase = 0; phase < 10; phase++) begin
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      if (phase == 1) begin
        lo = '0;
        hi = '0;
      end else if (phase == 2) begin
        lo = '1;
        hi = '1;
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) plen = 5'($urandom_range(1, 6));
      else if (pick < 9) plen = 5'($urandom_range(7, 16));
      else if ($urandom_range(0, 1) != 0) plen = 5'd0;
      else plen = 5'($urandom_range(17, 31));
      pick = $urandom_range(0, 9);
      if (pick < 4) mask = '0;
      else if (pick < 7) mask = 16'($urandom & $urandom & $urandom);
      else if (pick < 9) mask = 16'($urandom);
      else mask = '1;
      base = $urandom;
      if (phase == 3) base = 32'hffff_ffff - 32'($urandom_range(0, 20));
      program_search(lo, hi, mask, plen, base);
      sent = 0;
      while (sent < 160) begin
        n = $urandom_range(1, eff_len() + 12);
        pick = $urandom_range(0, 9);
        send_region(n, pick < 7, pick == 7);
        sent += n;
      end
      settle_idle();
    end
  endtask

  // closing stretch with no idling on either side
  task automatic test_steady_stream();
    int sent;
    int n;
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    program_search({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom & $urandom),
                   5'($urandom_range(1, 4)), $urandom);
    sent = 0;
    while (sent < 250) begin
      n = $urandom_range(1, eff_len() + 10);
      send_region(n, $urandom_range(0, 3) != 0, 1'b0);
      sent += n;
    end
    settle_idle();
  endtask

  // reset, test sequence and verdict
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = 8'h00;
    in_last_byte = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_PAT_LOW;
    cfg_data = '0;
    failures = 0;
    cycle_count = 0;
    sender_gaps = 1'b1;
    receiver_stalls = 1'b1;
    long_hold_cycles = 0;
    sig_lo = '0;
    sig_hi = '0;
    wild_mask = '0;
    sig_len = 5'd1;
    base_addr = '0;
    clear_scan();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_result_backlog();
    test_random_regions();
    test_steady_stream();

    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
